// ===== rtl/mipsdec_pkg.sv =====
// mipsdec_pkg: shared types, codes and lookup tables for the mips iii instruction decoder
// no dependencies; imported by mipsdec_decode and mips_instruction_decoder_top
package mipsdec_pkg;

    // width of the packed input transaction (word plus fpu flag, padded to bytes)
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 16;

    // primary opcodes with their own sub-decoders
    localparam logic [5:0] OP_SPECIAL = 6'b000000;
    localparam logic [5:0] OP_REGIMM  = 6'b000001;
    localparam logic [5:0] OP_COP0    = 6'b010000;
    localparam logic [5:0] OP_COP1    = 6'b010001;

    // coprocessor rs selectors
    localparam logic [4:0] RS_COP0_CO = 5'b10000;
    localparam logic [4:0] RS_COP1_BC = 5'b01000;
    localparam logic [5:0] FN_CMP_MASK = 6'h30;

    typedef enum logic [1:0] {
        EXC_NONE     = 2'd0,
        EXC_RESERVED = 2'd1,
        EXC_UNUSABLE = 2'd2
    } exc_code_t;

    // handler classes
    localparam logic [4:0] CLS_LOAD      = 5'd0;
    localparam logic [4:0] CLS_STORE     = 5'd1;
    localparam logic [4:0] CLS_ALU_IMM   = 5'd2;
    localparam logic [4:0] CLS_ALU_REG   = 5'd3;
    localparam logic [4:0] CLS_SHIFT     = 5'd4;
    localparam logic [4:0] CLS_MULDIV    = 5'd5;
    localparam logic [4:0] CLS_HILO      = 5'd6;
    localparam logic [4:0] CLS_JUMP      = 5'd7;
    localparam logic [4:0] CLS_BRANCH    = 5'd8;
    localparam logic [4:0] CLS_TRAP_REG  = 5'd9;
    localparam logic [4:0] CLS_TRAP_IMM  = 5'd10;
    localparam logic [4:0] CLS_BREAK     = 5'd11;
    localparam logic [4:0] CLS_SYNC      = 5'd12;
    localparam logic [4:0] CLS_SYSCALL   = 5'd13;
    localparam logic [4:0] CLS_COP0_MOVE = 5'd14;
    localparam logic [4:0] CLS_TLBP      = 5'd15;
    localparam logic [4:0] CLS_TLBR      = 5'd16;
    localparam logic [4:0] CLS_TLBWI     = 5'd17;
    localparam logic [4:0] CLS_TLBWR     = 5'd18;
    localparam logic [4:0] CLS_ERET      = 5'd19;
    localparam logic [4:0] CLS_CACHE     = 5'd20;
    localparam logic [4:0] CLS_FPU_LOAD  = 5'd21;
    localparam logic [4:0] CLS_FPU_STORE = 5'd22;
    localparam logic [4:0] CLS_FPU_MOVE  = 5'd23;
    localparam logic [4:0] CLS_FPU_CVT   = 5'd24;
    localparam logic [4:0] CLS_FPU_CALC  = 5'd25;
    localparam logic [4:0] CLS_FPU_BR    = 5'd26;
    localparam logic [4:0] CLS_FPU_CMP   = 5'd27;

    localparam logic [7:0] ID_FPU_COMPARE = 8'd85;

    // one table hit
    typedef struct packed {
        logic       hit;
        logic [7:0] id;
        logic [4:0] cls;
    } lookup_t;

    // decoded result, id in the low bits
    typedef struct packed {
        exc_code_t  exc;
        logic       recognized;
        logic [4:0] cls;
        logic [7:0] id;
    } dec_result_t;

    localparam lookup_t MISS = '{hit: 1'b0, id: 8'd0, cls: 5'd0};

    function automatic lookup_t mk(input logic [7:0] id, input logic [4:0] cls);
        lookup_t r;
        r.hit = 1'b1;
        r.id  = id;
        r.cls = cls;
        return r;
    endfunction

    function automatic lookup_t lookup_special(input logic [5:0] fn);
        lookup_t r;
        unique case (fn)
            6'h20: r = mk(8'd0,  CLS_ALU_REG);
            6'h21: r = mk(8'd1,  CLS_ALU_REG);
            6'h24: r = mk(8'd2,  CLS_ALU_REG);
            6'h2C: r = mk(8'd3,  CLS_ALU_REG);
            6'h2D: r = mk(8'd4,  CLS_ALU_REG);
            6'h2E: r = mk(8'd5,  CLS_ALU_REG);
            6'h2F: r = mk(8'd6,  CLS_ALU_REG);
            6'h27: r = mk(8'd7,  CLS_ALU_REG);
            6'h25: r = mk(8'd8,  CLS_ALU_REG);
            6'h2A: r = mk(8'd9,  CLS_ALU_REG);
            6'h2B: r = mk(8'd10, CLS_ALU_REG);
            6'h22: r = mk(8'd11, CLS_ALU_REG);
            6'h23: r = mk(8'd12, CLS_ALU_REG);
            6'h26: r = mk(8'd13, CLS_ALU_REG);
            6'h38: r = mk(8'd14, CLS_SHIFT);
            6'h14: r = mk(8'd15, CLS_SHIFT);
            6'h3C: r = mk(8'd16, CLS_SHIFT);
            6'h3B: r = mk(8'd17, CLS_SHIFT);
            6'h17: r = mk(8'd18, CLS_SHIFT);
            6'h3F: r = mk(8'd19, CLS_SHIFT);
            6'h3A: r = mk(8'd20, CLS_SHIFT);
            6'h16: r = mk(8'd21, CLS_SHIFT);
            6'h3E: r = mk(8'd22, CLS_SHIFT);
            6'h00: r = mk(8'd23, CLS_SHIFT);
            6'h04: r = mk(8'd24, CLS_SHIFT);
            6'h03: r = mk(8'd25, CLS_SHIFT);
            6'h07: r = mk(8'd26, CLS_SHIFT);
            6'h02: r = mk(8'd27, CLS_SHIFT);
            6'h06: r = mk(8'd28, CLS_SHIFT);
            6'h1E: r = mk(8'd29, CLS_MULDIV);
            6'h1F: r = mk(8'd30, CLS_MULDIV);
            6'h1A: r = mk(8'd31, CLS_MULDIV);
            6'h1B: r = mk(8'd32, CLS_MULDIV);
            6'h1C: r = mk(8'd33, CLS_MULDIV);
            6'h1D: r = mk(8'd34, CLS_MULDIV);
            6'h18: r = mk(8'd35, CLS_MULDIV);
            6'h19: r = mk(8'd36, CLS_MULDIV);
            6'h09: r = mk(8'd37, CLS_JUMP);
            6'h08: r = mk(8'd38, CLS_JUMP);
            6'h34: r = mk(8'd39, CLS_TRAP_REG);
            6'h30: r = mk(8'd40, CLS_TRAP_REG);
            6'h31: r = mk(8'd41, CLS_TRAP_REG);
            6'h32: r = mk(8'd42, CLS_TRAP_REG);
            6'h33: r = mk(8'd43, CLS_TRAP_REG);
            6'h36: r = mk(8'd44, CLS_TRAP_REG);
            6'h10: r = mk(8'd45, CLS_HILO);
            6'h12: r = mk(8'd46, CLS_HILO);
            6'h11: r = mk(8'd47, CLS_HILO);
            6'h13: r = mk(8'd48, CLS_HILO);
            6'h0D: r = mk(8'd49, CLS_BREAK);
            6'h0F: r = mk(8'd50, CLS_SYNC);
            6'h0C: r = mk(8'd51, CLS_SYSCALL);
            default: r = MISS;
        endcase
        return r;
    endfunction

    function automatic lookup_t lookup_regimm(input logic [4:0] rt);
        lookup_t r;
        unique case (rt)
            5'h01: r = mk(8'd52, CLS_BRANCH);
            5'h11: r = mk(8'd53, CLS_BRANCH);
            5'h13: r = mk(8'd54, CLS_BRANCH);
            5'h03: r = mk(8'd55, CLS_BRANCH);
            5'h00: r = mk(8'd56, CLS_BRANCH);
            5'h10: r = mk(8'd57, CLS_BRANCH);
            5'h12: r = mk(8'd58, CLS_BRANCH);
            5'h02: r = mk(8'd59, CLS_BRANCH);
            5'h0C: r = mk(8'd60, CLS_TRAP_IMM);
            5'h08: r = mk(8'd61, CLS_TRAP_IMM);
            5'h09: r = mk(8'd62, CLS_TRAP_IMM);
            5'h0A: r = mk(8'd63, CLS_TRAP_IMM);
            5'h0B: r = mk(8'd64, CLS_TRAP_IMM);
            5'h0E: r = mk(8'd65, CLS_TRAP_IMM);
            default: r = MISS;
        endcase
        return r;
    endfunction

    function automatic lookup_t lookup_cop0_co(input logic [5:0] fn);
        lookup_t r;
        unique case (fn)
            6'h18: r = mk(8'd66, CLS_ERET);
            6'h08: r = mk(8'd67, CLS_TLBP);
            6'h01: r = mk(8'd68, CLS_TLBR);
            6'h02: r = mk(8'd69, CLS_TLBWI);
            6'h06: r = mk(8'd70, CLS_TLBWR);
            default: r = MISS;
        endcase
        return r;
    endfunction

    function automatic lookup_t lookup_cop0_rs(input logic [4:0] rs);
        lookup_t r;
        unique case (rs)
            5'h01: r = mk(8'd71, CLS_COP0_MOVE);
            5'h05: r = mk(8'd72, CLS_COP0_MOVE);
            5'h00: r = mk(8'd73, CLS_COP0_MOVE);
            5'h04: r = mk(8'd74, CLS_COP0_MOVE);
            default: r = MISS;
        endcase
        return r;
    endfunction

    function automatic lookup_t lookup_cop1_bc(input logic [4:0] rt);
        lookup_t r;
        unique case (rt)
            5'h00: r = mk(8'd75, CLS_FPU_BR);
            5'h02: r = mk(8'd76, CLS_FPU_BR);
            5'h01: r = mk(8'd77, CLS_FPU_BR);
            5'h03: r = mk(8'd78, CLS_FPU_BR);
            default: r = MISS;
        endcase
        return r;
    endfunction

    function automatic lookup_t lookup_cop1_rs(input logic [4:0] rs);
        lookup_t r;
        unique case (rs)
            5'h02: r = mk(8'd79, CLS_FPU_MOVE);
            5'h06: r = mk(8'd80, CLS_FPU_MOVE);
            5'h01: r = mk(8'd81, CLS_FPU_MOVE);
            5'h05: r = mk(8'd82, CLS_FPU_MOVE);
            5'h00: r = mk(8'd83, CLS_FPU_MOVE);
            5'h04: r = mk(8'd84, CLS_FPU_MOVE);
            default: r = MISS;
        endcase
        return r;
    endfunction

    function automatic lookup_t lookup_cop1_fn(input logic [5:0] fn);
        lookup_t r;
        unique case (fn)
            6'h05: r = mk(8'd86,  CLS_FPU_CALC);
            6'h00: r = mk(8'd87,  CLS_FPU_CALC);
            6'h03: r = mk(8'd88,  CLS_FPU_CALC);
            6'h06: r = mk(8'd89,  CLS_FPU_CALC);
            6'h02: r = mk(8'd90,  CLS_FPU_CALC);
            6'h07: r = mk(8'd91,  CLS_FPU_CALC);
            6'h04: r = mk(8'd92,  CLS_FPU_CALC);
            6'h01: r = mk(8'd93,  CLS_FPU_CALC);
            6'h0A: r = mk(8'd94,  CLS_FPU_CVT);
            6'h0E: r = mk(8'd95,  CLS_FPU_CVT);
            6'h21: r = mk(8'd96,  CLS_FPU_CVT);
            6'h25: r = mk(8'd97,  CLS_FPU_CVT);
            6'h20: r = mk(8'd98,  CLS_FPU_CVT);
            6'h24: r = mk(8'd99,  CLS_FPU_CVT);
            6'h0B: r = mk(8'd100, CLS_FPU_CVT);
            6'h0F: r = mk(8'd101, CLS_FPU_CVT);
            6'h08: r = mk(8'd102, CLS_FPU_CVT);
            6'h0C: r = mk(8'd103, CLS_FPU_CVT);
            6'h09: r = mk(8'd104, CLS_FPU_CVT);
            6'h0D: r = mk(8'd105, CLS_FPU_CVT);
            default: r = MISS;
        endcase
        return r;
    endfunction

    function automatic lookup_t lookup_main(input logic [5:0] op);
        lookup_t r;
        unique case (op)
            6'h20: r = mk(8'd106, CLS_LOAD);
            6'h24: r = mk(8'd107, CLS_LOAD);
            6'h37: r = mk(8'd108, CLS_LOAD);
            6'h1A: r = mk(8'd109, CLS_LOAD);
            6'h1B: r = mk(8'd110, CLS_LOAD);
            6'h21: r = mk(8'd111, CLS_LOAD);
            6'h25: r = mk(8'd112, CLS_LOAD);
            6'h30: r = mk(8'd113, CLS_LOAD);
            6'h34: r = mk(8'd114, CLS_LOAD);
            6'h23: r = mk(8'd115, CLS_LOAD);
            6'h22: r = mk(8'd116, CLS_LOAD);
            6'h26: r = mk(8'd117, CLS_LOAD);
            6'h27: r = mk(8'd118, CLS_LOAD);
            6'h28: r = mk(8'd119, CLS_STORE);
            6'h38: r = mk(8'd120, CLS_STORE);
            6'h3C: r = mk(8'd121, CLS_STORE);
            6'h3F: r = mk(8'd122, CLS_STORE);
            6'h2C: r = mk(8'd123, CLS_STORE);
            6'h2D: r = mk(8'd124, CLS_STORE);
            6'h29: r = mk(8'd125, CLS_STORE);
            6'h2B: r = mk(8'd126, CLS_STORE);
            6'h2A: r = mk(8'd127, CLS_STORE);
            6'h2E: r = mk(8'd128, CLS_STORE);
            6'h08: r = mk(8'd129, CLS_ALU_IMM);
            6'h09: r = mk(8'd130, CLS_ALU_IMM);
            6'h0C: r = mk(8'd131, CLS_ALU_IMM);
            6'h18: r = mk(8'd132, CLS_ALU_IMM);
            6'h19: r = mk(8'd133, CLS_ALU_IMM);
            6'h0F: r = mk(8'd134, CLS_ALU_IMM);
            6'h0D: r = mk(8'd135, CLS_ALU_IMM);
            6'h0A: r = mk(8'd136, CLS_ALU_IMM);
            6'h0B: r = mk(8'd137, CLS_ALU_IMM);
            6'h0E: r = mk(8'd138, CLS_ALU_IMM);
            6'h02: r = mk(8'd139, CLS_JUMP);
            6'h03: r = mk(8'd140, CLS_JUMP);
            6'h04: r = mk(8'd141, CLS_BRANCH);
            6'h14: r = mk(8'd142, CLS_BRANCH);
            6'h07: r = mk(8'd143, CLS_BRANCH);
            6'h17: r = mk(8'd144, CLS_BRANCH);
            6'h06: r = mk(8'd145, CLS_BRANCH);
            6'h16: r = mk(8'd146, CLS_BRANCH);
            6'h05: r = mk(8'd147, CLS_BRANCH);
            6'h15: r = mk(8'd148, CLS_BRANCH);
            6'h2F: r = mk(8'd149, CLS_CACHE);
            6'h35: r = mk(8'd150, CLS_FPU_LOAD);
            6'h31: r = mk(8'd151, CLS_FPU_LOAD);
            6'h3D: r = mk(8'd152, CLS_FPU_STORE);
            6'h39: r = mk(8'd153, CLS_FPU_STORE);
            default: r = MISS;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/mips_instruction_decoder_top.sv =====
// mips_instruction_decoder_top: input register, decode logic and result register
// depends on mipsdec_pkg and mipsdec_decode
//
// channel   dir  handshake               payload
// s_axis    in   tvalid/tready           tdata[31:0] instruction_word, tdata[32] fpu_usable
// m_axis    out  tvalid/tready           tdata[7:0] id, [12:8] class, [13] recognized,
//                                        [15:14] exception_code
//
// one instruction per clock sustained while m_axis does not stall; an input transaction
// passes through the input register, then is decoded into the result register
// the throughput is set by the single decode pass between the two register stages
// rst_n clears both valid flags asynchronously; payload registers are not reset
// a stall on m_axis backs up one stage at a time, so the input keeps taking
// transactions until both registers hold data
module mips_instruction_decoder_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [31:0] instruction_word, [32] fpu_usable, [39:33] zero
    input  logic [mipsdec_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [7:0] instruction_id, [12:8] handler_class, [13] recognized, [15:14] exception_code
    output logic [mipsdec_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
    import mipsdec_pkg::*;

    // input stage
    logic        in_valid_reg;
    logic        in_valid_next;
    logic [31:0] in_word_reg;
    logic        in_fpu_reg;

    // result stage
    logic        out_valid_reg;
    logic        out_valid_next;
    dec_result_t out_result_reg;

    dec_result_t dec_result;
    logic        out_free;
    logic        s_accept;
    logic        adv;

    // result slot frees when empty or being taken this cycle
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign adv           = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    mipsdec_decode u_decode (
        .word       (in_word_reg),
        .fpu_usable (in_fpu_reg),
        .result     (dec_result)
    );

    always_comb
    begin
        in_valid_next  = s_accept ? 1'b1 : (adv ? 1'b0 : in_valid_reg);
        out_valid_next = adv ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_word_reg <= s_axis_tdata[31:0];
            in_fpu_reg  <= s_axis_tdata[32];
        end
        if (adv)
            out_result_reg <= dec_result;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_result_reg;

    // a recognized instruction never raises an exception
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_result_reg.recognized) |-> (out_result_reg.exc == EXC_NONE))
        else $error("recognized result carries an exception");

    // an unrecognized result reports id and class zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !out_result_reg.recognized) |->
            (out_result_reg.id == 8'd0 && out_result_reg.cls == 5'd0))
        else $error("unrecognized result has nonzero id or class");

    // a decoded word moves into an empty result slot on the next edge
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !out_valid_reg) |=> m_axis_tvalid)
        else $error("decoded transaction did not reach result register");

    // the fpu flag alone never produces a coprocessor-unusable result when set
    assert property (@(posedge clk) disable iff (!rst_n)
        (adv && in_fpu_reg) |=> (out_result_reg.exc != EXC_UNUSABLE))
        else $error("coprocessor unusable raised with fpu enabled");

endmodule

// ===== rtl/mipsdec_decode.sv =====
// mipsdec_decode: combinational decode of one instruction word into id, class and exception
// depends on mipsdec_pkg for the lookup tables and result type
module mipsdec_decode (
    input  logic [31:0]              word,
    input  logic                     fpu_usable,
    output mipsdec_pkg::dec_result_t result
);
    import mipsdec_pkg::*;

    logic [5:0] op;
    logic [4:0] rs;
    logic [4:0] rt;
    logic [5:0] fn;
    lookup_t    hit_special;
    lookup_t    hit_regimm;
    lookup_t    hit_cop0_co;
    lookup_t    hit_cop0_rs;
    lookup_t    hit_cop1_bc;
    lookup_t    hit_cop1_rs;
    lookup_t    hit_cop1_fn;
    lookup_t    hit_main;
    lookup_t    sel;
    exc_code_t  exc;

    assign op = word[31:26];
    assign rs = word[25:21];
    assign rt = word[20:16];
    assign fn = word[5:0];

    // all tables look up in parallel; the opcode, the rs field and, for cop1, the function field pick among them
    assign hit_special = lookup_special(fn);
    assign hit_regimm  = lookup_regimm(rt);
    assign hit_cop0_co = lookup_cop0_co(fn);
    assign hit_cop0_rs = lookup_cop0_rs(rs);
    assign hit_cop1_bc = lookup_cop1_bc(rt);
    assign hit_cop1_rs = lookup_cop1_rs(rs);
    assign hit_cop1_fn = lookup_cop1_fn(fn);
    assign hit_main    = lookup_main(op);

    always_comb
    begin
        sel = MISS;
        exc = EXC_NONE;
        unique case (op)
            OP_SPECIAL:
            begin
                sel = hit_special;
                if (!sel.hit)
                    exc = EXC_RESERVED;
            end
            OP_REGIMM:
            begin
                sel = hit_regimm;
                if (!sel.hit)
                    exc = EXC_RESERVED;
            end
            OP_COP0:
            begin
                if (rs == RS_COP0_CO)
                begin
                    // unknown co function is silently unrecognized
                    sel = hit_cop0_co;
                end
                else
                begin
                    sel = hit_cop0_rs;
                    if (!sel.hit)
                        exc = EXC_RESERVED;
                end
            end
            OP_COP1:
            begin
                if (!fpu_usable)
                    exc = EXC_UNUSABLE;
                else if (rs == RS_COP1_BC)
                begin
                    sel = hit_cop1_bc;
                    if (!sel.hit)
                        exc = EXC_RESERVED;
                end
                else if (hit_cop1_rs.hit)
                    sel = hit_cop1_rs;
                else if ((fn & FN_CMP_MASK) == FN_CMP_MASK)
                    sel = mk(ID_FPU_COMPARE, CLS_FPU_CMP);
                else
                    sel = hit_cop1_fn;
            end
            default:
            begin
                sel = hit_main;
                if (!sel.hit)
                    exc = EXC_RESERVED;
                else if ((sel.cls == CLS_FPU_LOAD || sel.cls == CLS_FPU_STORE) && !fpu_usable)
                begin
                    sel = MISS;
                    exc = EXC_UNUSABLE;
                end
            end
        endcase
    end

    always_comb
    begin
        result.exc        = exc;
        result.recognized = sel.hit;
        result.cls        = sel.hit ? sel.cls : 5'd0;
        result.id         = sel.hit ? sel.id : 8'd0;
    end

endmodule

// ===== sim/mips_instruction_decoder_top_test.sv =====
// self-checking testbench for mips_instruction_decoder_top: streams instruction words through
// the decoder under random input gaps and output stalls, predicts every result independently
// depends on mipsdec_pkg and the rtl under rtl/
module mips_instruction_decoder_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    import mipsdec_pkg::*;

    // clock, reset and run control
    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 10;
    localparam int RANDOM_ITEMS  = 250;
    localparam int HOLD_AT       = 150;   // accepted inputs before the long output stall
    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 2000;  // cycles with no transaction on either side
    localparam int DRAIN_CYCLES  = 20;
    localparam int REPORT_LIMIT  = 10;

    // instruction number ranges, one per decode table
    localparam int SPC_LO  = 0;
    localparam int SPC_HI  = 51;
    localparam int RIM_LO  = 52;
    localparam int RIM_HI  = 65;
    localparam int C0CO_LO = 66;
    localparam int C0CO_HI = 70;
    localparam int C0RS_LO = 71;
    localparam int C0RS_HI = 74;
    localparam int C1BC_LO = 75;
    localparam int C1BC_HI = 78;
    localparam int C1RS_LO = 79;
    localparam int C1RS_HI = 84;
    localparam int C1FN_LO = 86;
    localparam int C1FN_HI = 105;
    localparam int MAIN_LO = 106;
    localparam int MAIN_HI = 153;

    // selector code of each instruction number: function, rt, rs or opcode depending on range
    logic [5:0] code_of [0:153] = '{
        // special alu three operand
        6'h20, 6'h21, 6'h24, 6'h2C, 6'h2D, 6'h2E, 6'h2F, 6'h27, 6'h25, 6'h2A, 6'h2B, 6'h22,
        6'h23, 6'h26,
        // special shifts
        6'h38, 6'h14, 6'h3C, 6'h3B, 6'h17, 6'h3F, 6'h3A, 6'h16, 6'h3E, 6'h00, 6'h04, 6'h03,
        6'h07, 6'h02, 6'h06,
        // special multiply/divide, jumps, traps, hi/lo, break, sync, syscall
        6'h1E, 6'h1F, 6'h1A, 6'h1B, 6'h1C, 6'h1D, 6'h18, 6'h19,
        6'h09, 6'h08,
        6'h34, 6'h30, 6'h31, 6'h32, 6'h33, 6'h36,
        6'h10, 6'h12, 6'h11, 6'h13,
        6'h0D, 6'h0F, 6'h0C,
        // regimm rt
        6'h01, 6'h11, 6'h13, 6'h03, 6'h00, 6'h10, 6'h12, 6'h02, 6'h0C, 6'h08, 6'h09, 6'h0A,
        6'h0B, 6'h0E,
        // cop0 co function, cop0 rs
        6'h18, 6'h08, 6'h01, 6'h02, 6'h06,
        6'h01, 6'h05, 6'h00, 6'h04,
        // cop1 bc rt, cop1 move rs
        6'h00, 6'h02, 6'h01, 6'h03,
        6'h02, 6'h06, 6'h01, 6'h05, 6'h00, 6'h04,
        // compare slot, matched by its mask and never looked up
        FN_CMP_MASK,
        // cop1 compute and convert functions
        6'h05, 6'h00, 6'h03, 6'h06, 6'h02, 6'h07, 6'h04, 6'h01,
        6'h0A, 6'h0E, 6'h21, 6'h25, 6'h20, 6'h24, 6'h0B, 6'h0F, 6'h08, 6'h0C, 6'h09, 6'h0D,
        // primary opcodes: loads, stores
        6'h20, 6'h24, 6'h37, 6'h1A, 6'h1B, 6'h21, 6'h25, 6'h30, 6'h34, 6'h23, 6'h22, 6'h26,
        6'h27,
        6'h28, 6'h38, 6'h3C, 6'h3F, 6'h2C, 6'h2D, 6'h29, 6'h2B, 6'h2A, 6'h2E,
        // alu immediate, jumps, branches, cache, fpu load/store
        6'h08, 6'h09, 6'h0C, 6'h18, 6'h19, 6'h0F, 6'h0D, 6'h0A, 6'h0B, 6'h0E,
        6'h02, 6'h03,
        6'h04, 6'h14, 6'h07, 6'h17, 6'h06, 6'h16, 6'h05, 6'h15,
        6'h2F,
        6'h35, 6'h31, 6'h3D, 6'h39
    };

    // one instruction to send
    typedef struct packed {
        logic        fpu;
        logic [31:0] word;
    } insn_t;

    // expected decode results in arrival order, checked against the output stream
    class decode_scoreboard;
        dec_result_t pending[$];
        int          mismatches;

        function new();
            mismatches = 0;
        endfunction

        function void note_input(dec_result_t expected_result);
            pending.push_back(expected_result);
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] tdata);
            dec_result_t got;
            dec_result_t want;
            got = dec_result_t'(tdata);
            if (pending.size() == 0)
            begin
                if (mismatches < REPORT_LIMIT)
                    $display("unexpected result: id %0d class %0d rec %0b exc %0d",
                             got.id, got.cls, got.recognized, got.exc);
                mismatches++;
                return;
            end
            want = pending.pop_front();
            if (got.id !== want.id || got.cls !== want.cls ||
                got.recognized !== want.recognized || got.exc !== want.exc)
            begin
                if (mismatches < REPORT_LIMIT)
                begin
                    $write("mismatch: expected id %0d class %0d rec %0b exc %0d,",
                           want.id, want.cls, want.recognized, want.exc);
                    $display(" got id %0d class %0d rec %0b exc %0d",
                             got.id, got.cls, got.recognized, got.exc);
                end
                mismatches++;
            end
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;

    decode_scoreboard sb = new();
    insn_t            insn_queue[$];
    int               accepted_inputs = 0;
    int               idle_cycles = 0;

    mips_instruction_decoder_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // first instruction number in [lo, hi] whose code matches, -1 on a miss
    function automatic int find_code(input int lo, input int hi, input logic [5:0] code);
        for (int i = lo; i <= hi; i++)
            if (code_of[i] == code)
                return i;
        return -1;
    endfunction

    // handler class by instruction number range
    function automatic logic [4:0] handler_class_of(input int id);
        if (id <= 13)       return CLS_ALU_REG;
        else if (id <= 28)  return CLS_SHIFT;
        else if (id <= 36)  return CLS_MULDIV;
        else if (id <= 38)  return CLS_JUMP;
        else if (id <= 44)  return CLS_TRAP_REG;
        else if (id <= 48)  return CLS_HILO;
        else if (id == 49)  return CLS_BREAK;
        else if (id == 50)  return CLS_SYNC;
        else if (id == 51)  return CLS_SYSCALL;
        else if (id <= 59)  return CLS_BRANCH;
        else if (id <= 65)  return CLS_TRAP_IMM;
        else if (id == 66)  return CLS_ERET;
        else if (id == 67)  return CLS_TLBP;
        else if (id == 68)  return CLS_TLBR;
        else if (id == 69)  return CLS_TLBWI;
        else if (id == 70)  return CLS_TLBWR;
        else if (id <= 74)  return CLS_COP0_MOVE;
        else if (id <= 78)  return CLS_FPU_BR;
        else if (id <= 84)  return CLS_FPU_MOVE;
        else if (id == 85)  return CLS_FPU_CMP;
        else if (id <= 93)  return CLS_FPU_CALC;
        else if (id <= 105) return CLS_FPU_CVT;
        else if (id <= 118) return CLS_LOAD;
        else if (id <= 128) return CLS_STORE;
        else if (id <= 138) return CLS_ALU_IMM;
        else if (id <= 140) return CLS_JUMP;
        else if (id <= 148) return CLS_BRANCH;
        else if (id == 149) return CLS_CACHE;
        else if (id <= 151) return CLS_FPU_LOAD;
        else                return CLS_FPU_STORE;
    endfunction

    // expected decode of one instruction word
    function automatic dec_result_t predict_decode(input logic [31:0] w, input logic fpu);
        dec_result_t r;
        int          hit;
        logic [5:0]  op;
        logic [4:0]  rs;
        logic [4:0]  rt;
        logic [5:0]  fn;
        op  = w[31:26];
        rs  = w[25:21];
        rt  = w[20:16];
        fn  = w[5:0];
        r   = '0;
        r.exc = EXC_NONE;
        hit = -1;
        case (op)
            OP_SPECIAL:
            begin
                hit = find_code(SPC_LO, SPC_HI, fn);
                if (hit < 0)
                    r.exc = EXC_RESERVED;
            end
            OP_REGIMM:
            begin
                hit = find_code(RIM_LO, RIM_HI, {1'b0, rt});
                if (hit < 0)
                    r.exc = EXC_RESERVED;
            end
            OP_COP0:
            begin
                // unknown co function is silently unrecognized
                if (rs == RS_COP0_CO)
                    hit = find_code(C0CO_LO, C0CO_HI, fn);
                else
                begin
                    hit = find_code(C0RS_LO, C0RS_HI, {1'b0, rs});
                    if (hit < 0)
                        r.exc = EXC_RESERVED;
                end
            end
            OP_COP1:
            begin
                if (!fpu)
                    r.exc = EXC_UNUSABLE;
                else if (rs == RS_COP1_BC)
                begin
                    hit = find_code(C1BC_LO, C1BC_HI, {1'b0, rt});
                    if (hit < 0)
                        r.exc = EXC_RESERVED;
                end
                else
                begin
                    hit = find_code(C1RS_LO, C1RS_HI, {1'b0, rs});
                    if (hit < 0)
                    begin
                        if ((fn & FN_CMP_MASK) == FN_CMP_MASK)
                            hit = int'(ID_FPU_COMPARE);
                        else
                            hit = find_code(C1FN_LO, C1FN_HI, fn);
                    end
                end
            end
            default:
            begin
                hit = find_code(MAIN_LO, MAIN_HI, op);
                if (hit < 0)
                    r.exc = EXC_RESERVED;
                else if (!fpu && (handler_class_of(hit) == CLS_FPU_LOAD ||
                                  handler_class_of(hit) == CLS_FPU_STORE))
                begin
                    hit   = -1;
                    r.exc = EXC_UNUSABLE;
                end
            end
        endcase
        if (hit >= 0)
        begin
            r.id         = 8'(hit);
            r.cls        = handler_class_of(hit);
            r.recognized = 1'b1;
        end
        return r;
    endfunction

    // random instruction word that decodes to the given instruction number
    function automatic logic [31:0] word_for_id(input int id);
        logic [31:0] w;
        logic [4:0]  rs;
        w = $urandom;
        if (id <= SPC_HI)
        begin
            w[31:26] = OP_SPECIAL;
            w[5:0]   = code_of[id];
        end
        else if (id <= RIM_HI)
        begin
            w[31:26] = OP_REGIMM;
            w[20:16] = code_of[id][4:0];
        end
        else if (id <= C0CO_HI)
        begin
            w[31:26] = OP_COP0;
            w[25:21] = RS_COP0_CO;
            w[5:0]   = code_of[id];
        end
        else if (id <= C0RS_HI)
        begin
            w[31:26] = OP_COP0;
            w[25:21] = code_of[id][4:0];
        end
        else if (id <= C1BC_HI)
        begin
            w[31:26] = OP_COP1;
            w[25:21] = RS_COP1_BC;
            w[20:16] = code_of[id][4:0];
        end
        else if (id <= C1RS_HI)
        begin
            w[31:26] = OP_COP1;
            w[25:21] = code_of[id][4:0];
        end
        else if (id <= C1FN_HI)
        begin
            // arithmetic format: any rs that is neither bc nor a move
            do
                rs = 5'($urandom_range(0, 31));
            while (rs == RS_COP1_BC || find_code(C1RS_LO, C1RS_HI, {1'b0, rs}) >= 0);
            w[31:26] = OP_COP1;
            w[25:21] = rs;
            if (id == int'(ID_FPU_COMPARE))
                w[5:4] = 2'b11;
            else
                w[5:0] = code_of[id];
        end
        else
            w[31:26] = code_of[id];
        return w;
    endfunction

    function automatic void add_insn(input logic [31:0] w, input logic fpu);
        insn_t it;
        it.word = w;
        it.fpu  = fpu;
        insn_queue.push_back(it);
    endfunction

    // offer one instruction and hold it until the decoder takes it
    task automatic send_instruction(input insn_t it);
        s_axis_tdata  <= {7'b0, it.fpu, it.word};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // transaction monitor: both sides sampled at the edge, before any update of this edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                sb.note_input(predict_decode(s_axis_tdata[31:0], s_axis_tdata[32]));
                accepted_inputs++;
            end
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
    end

    // receiver: rotating stall pattern, plus one long hold-off that backs the pipe up
    initial
    begin : receiver
        int cyc;
        bit held;
        cyc  = 0;
        held = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && !held && accepted_inputs >= HOLD_AT)
            begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            case ((cyc / 50) % 4)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= ((cyc % 3) == 0);
                2:       m_axis_tready <= 1'($urandom_range(0, 1));
                default: m_axis_tready <= ($urandom_range(0, 4) != 0);
            endcase
            cyc++;
        end
    end

    // watchdog: nothing moving on either side for too long
    initial
    begin
        wait (rst_n === 1'b1);
        while (idle_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("CHECKS FAILED");
        $finish;
    end

    // main sequence: reset, stimulus in bursts, drain, verdict
    initial
    begin
        int sweep[$];
        int burst;
        int gap;
        int k;
        logic [31:0] w;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // directed: field extremes and every special decode path
        add_insn(32'h0000_0000, 1'b0);                              // all zero, sll
        add_insn(32'hFFFF_FFFF, 1'b1);                              // all ones, sd
        add_insn(32'hFFFF_FFFF, 1'b0);
        add_insn({OP_SPECIAL, 20'hFFFFF, 6'h0D}, 1'b1);             // break with full fields
        add_insn({OP_SPECIAL, 20'h0, 6'h01}, 1'b1);                 // unknown special function
        add_insn({OP_REGIMM, 5'h0, 5'h04, 16'h0}, 1'b1);            // unknown regimm rt
        add_insn({OP_REGIMM, 5'h1F, 5'h11, 16'hFFFF}, 1'b0);        // bgezal
        add_insn({OP_COP0, RS_COP0_CO, 15'h0, 6'h18}, 1'b1);        // eret
        add_insn({OP_COP0, RS_COP0_CO, 15'h0, 6'h08}, 1'b0);        // tlbp
        add_insn({OP_COP0, RS_COP0_CO, 15'h7FFF, 6'h3F}, 1'b1);     // unknown co function
        add_insn({OP_COP0, 5'h11, 15'h0, 6'h18}, 1'b1);             // rs bit 4 set, not co
        add_insn({OP_COP0, 5'h04, 21'h0}, 1'b1);                    // mtc0
        add_insn({OP_COP1, 5'h10, 15'h0, 6'h00}, 1'b0);             // cop1 while disabled
        add_insn({OP_COP1, RS_COP1_BC, 5'h03, 16'h0}, 1'b1);        // bc1tl
        add_insn({OP_COP1, RS_COP1_BC, 5'h1F, 16'h0}, 1'b1);        // unknown bc rt
        add_insn({OP_COP1, 5'h06, 21'h0}, 1'b1);                    // ctc1
        add_insn({OP_COP1, 5'h10, 15'h0, 6'h3C}, 1'b1);             // c.cond compare
        add_insn({OP_COP1, 5'h11, 15'h0, 6'h21}, 1'b1);             // cvt.d
        add_insn({OP_COP1, 5'h10, 15'h0, 6'h1F}, 1'b1);             // unknown fpu function
        add_insn({6'h31, 26'h0}, 1'b0);                             // lwc1 while disabled
        add_insn({6'h3D, 26'h3FFFFFF}, 1'b1);                       // sdc1
        add_insn({6'h3B, 26'h0}, 1'b1);                             // unused opcode
        add_insn({6'h12, 26'h0}, 1'b1);                             // cop2, reserved
        add_insn({6'h2F, 26'h1234567}, 1'b0);                       // cache

        // every instruction once, in shuffled order with random filler bits
        for (int i = 0; i <= MAIN_HI; i++)
            sweep.push_back(i);
        sweep.shuffle();
        foreach (sweep[i])
            add_insn(word_for_id(sweep[i]), $urandom_range(0, 7) != 0);

        // two in five well-formed words, the rest random sub-fields and raw noise
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            k = $urandom_range(0, 9);
            w = $urandom;
            if (k <= 3)
                w = word_for_id($urandom_range(0, MAIN_HI));
            else if (k == 4)
                w[31:26] = OP_SPECIAL;
            else if (k == 5)
                w[31:26] = OP_REGIMM;
            else if (k == 6)
            begin
                w[31:26] = OP_COP0;
                if ($urandom_range(0, 1) == 0)
                    w[25:21] = RS_COP0_CO;
            end
            else if (k == 7)
            begin
                w[31:26] = OP_COP1;
                if ($urandom_range(0, 2) == 0)
                    w[25:21] = RS_COP1_BC;
            end
            add_insn(w, $urandom_range(0, 7) != 0);
        end

        @(posedge clk);

        // sender: bursts of random length, idle gaps between them, some back to back
        while (insn_queue.size() != 0)
        begin
            burst = $urandom_range(1, 16);
            while (burst != 0 && insn_queue.size() != 0)
            begin
                send_instruction(insn_queue.pop_front());
                burst--;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_axis_tvalid <= 1'b0;

        // wait for every outstanding result, then watch for strays
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
